// ----- rtl/core/sphe_pkg.sv -----
// ----------------------------------------------------------------------------
// sphe_pkg
// Shared types, request codes and modular arithmetic helpers for the
// substring polynomial hash engine (modulus 2^61-1).
// ----------------------------------------------------------------------------
package sphe_pkg;

    localparam int unsigned HashW = 61;
    localparam int unsigned ElemW = 32;
    localparam logic [HashW-1:0] HashMod = {HashW{1'b1}};
    localparam logic [HashW-1:0] ElemOffset = 61'd997;
    localparam logic [HashW-1:0] BaseReset = 61'd768614336404564650;

    // Capacity of the element store; the range ports address it with 12 bits
    localparam int unsigned MaxLen = 4096;

    // Request codes
    localparam logic [2:0] ReqClear = 3'd0;
    localparam logic [2:0] ReqAppend = 3'd1;
    localparam logic [2:0] ReqSeal = 3'd2;
    localparam logic [2:0] ReqFwd = 3'd3;
    localparam logic [2:0] ReqRev = 3'd4;

    // Status codes
    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StBadRange = 2'd1;
    localparam logic [1:0] StFull = 2'd2;
    localparam logic [1:0] StNotSealed = 2'd3;

    // Fold a sum below 2^64 into 0..P-1
    function automatic logic [HashW-1:0] fold_mod(input logic [63:0] s);
        logic [63:0] t;
        logic [63:0] u;
        t = {3'b0, s[60:0]} + {61'b0, s[63:61]};
        u = {3'b0, t[60:0]} + {61'b0, t[63:61]};
        if (u[60:0] == HashMod) begin
            return '0;
        end
        return u[60:0];
    endfunction

    function automatic logic [HashW-1:0] add_elem(input logic [HashW-1:0] h,
                                                 input logic [ElemW-1:0] e);
        logic [62:0] s;
        s = {2'b0, h} + {31'b0, e} + {2'b0, ElemOffset};
        if (s >= {2'b0, HashMod}) begin
            s = s - {2'b0, HashMod};
        end
        return s[60:0];
    endfunction

    function automatic logic [HashW-1:0] sub_mod(input logic [HashW-1:0] a,
                                                input logic [HashW-1:0] b);
        logic [61:0] d;
        if (a >= b) begin
            d = {1'b0, a} - {1'b0, b};
        end else begin
            d = {1'b0, a} + {1'b0, HashMod} - {1'b0, b};
        end
        return d[60:0];
    endfunction

endpackage

// ----- rtl/core/sphe_ram.sv -----
// ----------------------------------------------------------------------------
// sphe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sphe_ram #(
    parameter int unsigned Width = 61,
    parameter int unsigned Depth = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/sphe_mulmod.sv -----
// ----------------------------------------------------------------------------
// sphe_mulmod
// Pipelined (x*y) mod 2^61-1: partial products registered, then folded.
// ----------------------------------------------------------------------------
module sphe_mulmod
    import sphe_pkg::*;
(
    input  logic             i_clk,
    input  logic [HashW-1:0] i_x,
    input  logic [HashW-1:0] i_y,
    output logic [HashW-1:0] o_p
);
    logic [63:0] r_lo;
    logic [63:0] r_m0;
    logic [63:0] r_m1;
    logic [63:0] r_hi;
    logic [HashW-1:0] r_p;
    logic [64:0] mid;
    logic [63:0] s;

    // Stage one: four partial products of the 32-bit and 29-bit halves
    always_ff @(posedge i_clk) begin
        r_lo <= {32'b0, i_x[31:0]} * {32'b0, i_y[31:0]};
        r_m0 <= {32'b0, i_x[31:0]} * {35'b0, i_y[60:32]};
        r_m1 <= {35'b0, i_x[60:32]} * {32'b0, i_y[31:0]};
        r_hi <= {35'b0, i_x[60:32]} * {35'b0, i_y[60:32]};
    end

    // Stage two: fold 2^61 = 1
    always_comb begin
        mid = {1'b0, r_m0} + {1'b0, r_m1};
        s = {3'b0, r_lo[60:0]} + {61'b0, r_lo[63:61]} + {r_hi[60:0], 3'b0}
            + {28'b0, mid[64:29]} + {3'b0, mid[28:0], 32'b0};
    end

    always_ff @(posedge i_clk) begin
        r_p <= fold_mod(s);
    end

    assign o_p = r_p;
endmodule

// ----- rtl/core/substring_poly_hash_engine_unit.sv -----
// ----------------------------------------------------------------------------
// substring_poly_hash_engine_unit
// Prefix, power and suffix hash tables over a stored sequence, mod 2^61-1.
// ----------------------------------------------------------------------------
//  channel  | direction | signals
//  request  | in        | start, i_req_type, i_element_value, i_range_* (busy is out)
//  result   | out       | o_done, o_status, o_hash_value
//  config   | in        | i_cfg_we, i_cfg_wdata (hash_base)
//
// Append and good queries read the tables, then make two passes through the
// multiplier with write-back; bad requests, clear, unused codes and a seal of
// an empty store go straight to the finish state. A seal walks the store from
// its end, each suffix step waiting on the previous through the multiplier.
// The result strobe is high in the first cycle that busy is low. Reset and
// base writes clear length and sealed flag; fixed table entries are flagged
// at read time. Results cannot be stalled.
// ----------------------------------------------------------------------------
module substring_poly_hash_engine_unit
    import sphe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       i_req_type,
    input  logic [ElemW-1:0] i_element_value,
    input  logic [11:0]      i_range_start,
    input  logic [11:0]      i_range_end,
    input  logic             i_cfg_we,
    input  logic [HashW-1:0] i_cfg_wdata,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [HashW-1:0] o_hash_value
);
    localparam int unsigned AW = $clog2(MaxLen + 2);
    localparam int unsigned LW = $clog2(MaxLen + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_W1   = 7'b0001000,
        S_W2   = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_SEAL = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [HashW-1:0] r_base;
    logic [LW-1:0] r_len;
    logic r_sealed;
    logic [2:0] r_req;
    logic [ElemW-1:0] r_elem;
    logic [AW-1:0] r_l, r_r;
    logic [LW-1:0] r_idx;
    logic [HashW-1:0] r_acc;
    logic r_pre_z, r_pow_z, r_suf_z;
    logic r_done;
    logic [1:0] r_status;
    logic [HashW-1:0] r_hash;
    logic [1:0] r_step;

    // Memory ports
    logic pre_we, pow_we, suf_we, el_we;
    logic [AW-1:0] pre_ra, pow_ra, suf_ra, pre_wa, pow_wa, suf_wa, el_a;
    logic [HashW-1:0] pre_wd, pow_wd, suf_wd;
    logic [HashW-1:0] pre_rd, pow_rd, suf_rd;
    logic [ElemW-1:0] el_rd;
    logic [HashW-1:0] mx, my, mp;
    logic [HashW-1:0] pre_v, pow_v, suf_v;
    logic req_ok;

    sphe_ram #(.Width(HashW), .Depth(MaxLen + 2)) u_pre (
        .i_clk, .i_we(pre_we), .i_waddr(pre_wa), .i_wdata(pre_wd),
        .i_raddr(pre_ra), .o_rdata(pre_rd));
    sphe_ram #(.Width(HashW), .Depth(MaxLen + 2)) u_pow (
        .i_clk, .i_we(pow_we), .i_waddr(pow_wa), .i_wdata(pow_wd),
        .i_raddr(pow_ra), .o_rdata(pow_rd));
    sphe_ram #(.Width(HashW), .Depth(MaxLen + 2)) u_suf (
        .i_clk, .i_we(suf_we), .i_waddr(suf_wa), .i_wdata(suf_wd),
        .i_raddr(suf_ra), .o_rdata(suf_rd));
    sphe_ram #(.Width(ElemW), .Depth(MaxLen + 2)) u_el (
        .i_clk, .i_we(el_we), .i_waddr(el_a), .i_wdata(r_elem),
        .i_raddr(el_a), .o_rdata(el_rd));

    sphe_mulmod u_mul (.i_clk, .i_x(mx), .i_y(my), .o_p(mp));

    assign busy = (r_state != S_IDLE);
    assign req_ok = (r_l <= r_r) && ({1'b0, r_r} < {1'b0, r_len});

    // Entry zero of prefix/power is fixed, suffix past end reads as zero;
    // the flags are registered from the read address like the data
    assign pre_v = r_pre_z ? '0 : pre_rd;
    assign pow_v = r_pow_z ? 61'd1 : pow_rd;
    assign suf_v = r_suf_z ? '0 : suf_rd;

    // Addresses and multiplier operands
    always_comb begin
        pre_ra = '0; pow_ra = '0; suf_ra = '0;
        el_a = AW'(r_idx) - AW'(1);
        mx = r_base; my = r_base;
        unique case (r_req)
            ReqAppend: begin
                pre_ra = AW'(r_len); pow_ra = AW'(r_len);
                el_a = AW'(r_len);
                mx = (r_step == 2'd1) ? pow_v : pre_v; my = r_base;
            end
            ReqFwd: begin
                pre_ra = (r_state == S_RD) ? r_l : r_r + AW'(1);
                pow_ra = r_r - r_l + AW'(1);
                mx = pow_v; my = pre_v;
            end
            ReqRev: begin
                suf_ra = (r_state == S_RD) ? r_r + AW'(2) : r_l + AW'(1);
                pow_ra = r_r - r_l + AW'(1);
                mx = pow_v; my = suf_v;
            end
            default: begin
                mx = r_acc;
            end
        endcase
    end

    // Write ports
    always_comb begin
        pre_we = 1'b0; pow_we = 1'b0; suf_we = 1'b0; el_we = 1'b0;
        pre_wa = AW'(r_len) + AW'(1); pow_wa = pre_wa; suf_wa = AW'(r_idx);
        pre_wd = add_elem(r_acc, r_elem); pow_wd = mp;
        suf_wd = add_elem(mp, el_rd);
        if (r_req == ReqAppend && r_state == S_W2 && r_step == 2'd1) begin
            pre_we = 1'b1; pow_we = 1'b1; el_we = 1'b1;
        end
        if (r_state == S_SEAL && r_step == 2'd3) begin
            suf_we = 1'b1;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_RD;
            S_RD: begin
                priority if (r_req == ReqAppend) begin
                    n_state = ({1'b0, r_len} >= (LW+1)'(MaxLen)) ? S_FIN : S_MUL;
                end else if (r_req == ReqSeal) begin
                    n_state = (r_len == '0) ? S_FIN : S_SEAL;
                end else if (r_req == ReqFwd || r_req == ReqRev) begin
                    n_state = ((r_req == ReqRev && !r_sealed) || !req_ok) ? S_FIN : S_MUL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MUL: n_state = S_W1;
            S_W1: n_state = S_W2;
            S_W2: n_state = (r_step == 2'd1) ? S_FIN : S_MUL;
            S_FIN: n_state = S_IDLE;
            S_SEAL: if (r_step == 2'd3 && r_idx == LW'(1)) n_state = S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base <= BaseReset;
            r_len <= '0;
            r_sealed <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done <= (r_state == S_FIN);
            if (i_cfg_we) begin
                r_base <= (i_cfg_wdata == HashMod) ? '0 : i_cfg_wdata;
                r_len <= '0;
                r_sealed <= 1'b0;
            end
            if (r_state == S_RD && r_req == ReqClear) begin
                r_len <= '0;
                r_sealed <= 1'b0;
            end
            if (r_state == S_W2 && r_req == ReqAppend && r_step == 2'd1) begin
                r_len <= r_len + LW'(1);
                r_sealed <= 1'b0;
            end
            if (r_state == S_RD && r_req == ReqSeal) begin
                r_sealed <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_pre_z <= (pre_ra == '0);
        r_pow_z <= (pow_ra == '0);
        r_suf_z <= (suf_ra == AW'(r_len) + AW'(1));
        unique case (r_state)
            S_IDLE: begin
                r_req <= i_req_type; r_elem <= i_element_value;
                r_l <= AW'(i_range_start); r_r <= AW'(i_range_end);
                r_step <= '0; r_acc <= '0;
                r_status <= StOk; r_hash <= '0;
            end
            S_RD: begin
                r_idx <= r_len;
                if (r_req == ReqAppend && {1'b0, r_len} >= (LW+1)'(MaxLen))
                    r_status <= StFull;
                if (r_req == ReqRev && !r_sealed) r_status <= StNotSealed;
                else if ((r_req == ReqFwd || r_req == ReqRev) && !req_ok)
                    r_status <= StBadRange;
            end
            S_MUL: begin
                // Latch the table entry that the product is taken from
                if (r_req != ReqAppend) begin
                    r_acc <= (r_req == ReqRev) ? suf_v : pre_v;
                end
            end
            S_W1: ;
            S_W2: begin
                if (r_step == 2'd0) begin
                    r_step <= 2'd1;
                    if (r_req == ReqAppend) r_acc <= mp;
                    else r_hash <= mp;
                end else if (r_req != ReqAppend) begin
                    r_hash <= sub_mod(r_acc, r_hash);
                end
            end
            S_SEAL: begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_acc <= suf_wd;
                    r_idx <= r_idx - LW'(1);
                end
            end
            S_FIN: ;
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_status = r_status;
    assign o_hash_value = r_hash;

    // Checks
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held");
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_len} <= (LW+1)'(MaxLen))) else $error("length overflow");
    a_hash_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != StOk) |-> (o_hash_value == '0))
        else $error("hash on error");
endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the substring polynomial hash engine: a queue-fed
// driver, a result monitor and a bit-exact predictor of the hash tables,
// run over several base settings with directed, random and long-sequence items.
// ----------------------------------------------------------------------------
module tb
    import sphe_pkg::*;
();

    localparam int unsigned WatchLimit = 100000;
    localparam int unsigned LongLen = 300;
    localparam logic [2:0] ReqSpare = 3'd5;

    typedef struct packed {
        logic [2:0]       req;
        logic [ElemW-1:0] elem;
        logic [11:0]      lo;
        logic [11:0]      hi;
    } t_hash_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [HashW-1:0] hash;
    } t_hash_res;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [2:0]       i_req_type = '0;
    logic [ElemW-1:0] i_element_value = '0;
    logic [11:0]      i_range_start = '0;
    logic [11:0]      i_range_end = '0;
    logic             i_cfg_we = 1'b0;
    logic [HashW-1:0] i_cfg_wdata = '0;
    logic             o_done;
    logic [1:0]       o_status;
    logic [HashW-1:0] o_hash_value;

    substring_poly_hash_engine_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_element_value(i_element_value),
        .i_range_start(i_range_start), .i_range_end(i_range_end),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_done(o_done), .o_status(o_status), .o_hash_value(o_hash_value)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Shadow copy of the engine state
    logic [ElemW-1:0] elem_mem [MaxLen];
    logic [HashW-1:0] pre_hash [MaxLen+1];
    logic [HashW-1:0] suf_hash [MaxLen+2];
    logic [HashW-1:0] pow_tab [MaxLen+1];
    int unsigned      cur_len = 0;
    bit               is_sealed = 0;
    logic [HashW-1:0] base_val = BaseReset;

    t_hash_req   pending_q [$];
    t_hash_res   expected_q [$];
    t_hash_req   in_flight;
    int unsigned n_items = 0;
    int unsigned n_results = 0;
    int unsigned n_errors = 0;
    int unsigned n_bases = 0;
    int unsigned idle_cnt = 0;
    int unsigned gen_len = 0;
    bit          quiet = 0;

    function automatic logic [HashW-1:0] mulm(input logic [HashW-1:0] a,
                                             input logic [HashW-1:0] b);
        logic [127:0] w;
        w = ({67'b0, a} * {67'b0, b}) % {67'b0, HashMod};
        return w[HashW-1:0];
    endfunction

    function automatic logic [HashW-1:0] plus_elem(input logic [HashW-1:0] h,
                                                  input logic [ElemW-1:0] e);
        logic [63:0] s;
        s = {3'b0, h} + {32'b0, e} + 64'd997;
        if (s >= {3'b0, HashMod}) s = s - {3'b0, HashMod};
        return s[HashW-1:0];
    endfunction

    function automatic logic [HashW-1:0] minus_mod(input logic [HashW-1:0] a,
                                                  input logic [HashW-1:0] b);
        logic [63:0] d;
        d = (a >= b) ? {3'b0, a} - {3'b0, b} : {3'b0, a} + {3'b0, HashMod} - {3'b0, b};
        return d[HashW-1:0];
    endfunction

    function automatic void drop_sequence();
        cur_len = 0;
        is_sealed = 0;
        pre_hash[0] = '0;
        pow_tab[0] = 61'd1;
    endfunction

    // Work out the result of one accepted item and advance the shadow state
    function automatic t_hash_res hash_predict(input t_hash_req q);
        t_hash_res   res;
        int unsigned l;
        int unsigned r;
        res = '0;
        l = 32'(q.lo);
        r = 32'(q.hi);
        case (q.req)
            ReqClear: drop_sequence();
            ReqAppend: begin
                if (cur_len >= MaxLen) begin
                    res.status = StFull;
                end else begin
                    elem_mem[cur_len] = q.elem;
                    pre_hash[cur_len+1] = plus_elem(mulm(pre_hash[cur_len], base_val), q.elem);
                    pow_tab[cur_len+1] = mulm(pow_tab[cur_len], base_val);
                    cur_len++;
                    is_sealed = 0;
                end
            end
            ReqSeal: begin
                suf_hash[cur_len+1] = '0;
                for (int i = cur_len; i >= 1; i--)
                    suf_hash[i] = plus_elem(mulm(suf_hash[i+1], base_val), elem_mem[i-1]);
                is_sealed = 1;
            end
            ReqFwd, ReqRev: begin
                if (q.req == ReqRev && !is_sealed) res.status = StNotSealed;
                else if (l > r || r >= cur_len) res.status = StBadRange;
                else if (q.req == ReqFwd)
                    res.hash = minus_mod(pre_hash[r+1], mulm(pow_tab[r-l+1], pre_hash[l]));
                else
                    res.hash = minus_mod(suf_hash[l+1], mulm(pow_tab[r-l+1], suf_hash[r+2]));
            end
            default: ;
        endcase
        return res;
    endfunction

    // Driver: record the accepted item, then offer the next one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_q.push_back(hash_predict(in_flight));
                n_items++;
            end
            if (!start || !busy) begin
                if (pending_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
                    in_flight = pending_q.pop_front();
                    start <= 1'b1;
                    i_req_type <= in_flight.req;
                    i_element_value <= in_flight.elem;
                    i_range_start <= in_flight.lo;
                    i_range_end <= in_flight.hi;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_hash_res e;
        if (i_rst_n && o_done) begin
            n_results++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result status %0d hash %0h", $time,
                         o_status, o_hash_value);
                n_errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status,
                             o_status);
                    n_errors++;
                end
                if (o_hash_value !== e.hash) begin
                    $display("%0t: hash expected %0h actual %0h", $time, e.hash,
                             o_hash_value);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: count cycles in which nothing moves
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WatchLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic add_item(input logic [2:0] req, input logic [ElemW-1:0] elem,
                            input logic [11:0] lo, input logic [11:0] hi);
        t_hash_req q;
        q.req = req;
        q.elem = elem;
        q.lo = lo;
        q.hi = hi;
        pending_q.push_back(q);
        if (req == ReqClear) gen_len = 0;
        else if (req == ReqAppend && gen_len < MaxLen) gen_len++;
    endtask

    // Hold the sender until the engine has emptied out
    task automatic drain();
        wait (pending_q.size() == 0 && expected_q.size() == 0);
        repeat (4) @(posedge i_clk);
        wait (!busy);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [HashW-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        base_val = (v >= HashMod) ? v - HashMod : v;
        drop_sequence();
        gen_len = 0;
        n_bases++;
    endtask

    task automatic random_items(input int unsigned count);
        int unsigned k;
        int unsigned l;
        int unsigned sel;
        int unsigned made;
        made = 0;
        while (made < count) begin
            sel = $urandom_range(0, 99);
            if (gen_len > 200) begin
                add_item(ReqClear, $urandom, 12'($urandom), 12'($urandom));
                made++;
            end else if (sel < 6) begin
                add_item(ReqClear, $urandom, 12'($urandom), 12'($urandom));
                made++;
            end else if (sel < 45) begin
                k = $urandom_range(1, 12);
                repeat (k) add_item(ReqAppend, $urandom, 12'($urandom), 12'($urandom));
                made += k;
            end else if (sel < 57) begin
                add_item(ReqSeal, $urandom, 12'($urandom), 12'($urandom));
                made++;
            end else if (sel < 88 && gen_len > 0) begin
                l = $urandom_range(0, gen_len - 1);
                add_item((sel < 72) ? ReqFwd : ReqRev, $urandom, l[11:0],
                         12'($urandom_range(l, gen_len - 1)));
                made++;
            end else if (sel < 95) begin
                add_item(($urandom_range(0, 1) == 1) ? ReqFwd : ReqRev, $urandom,
                         12'($urandom), 12'($urandom));
                made++;
            end else begin
                add_item(3'($urandom_range(ReqSpare, 7)), $urandom, 12'($urandom),
                         12'($urandom));
                made++;
            end
        end
    endtask

    initial begin
        logic [HashW-1:0] bases [6];
        bases[0] = 61'd2;
        bases[1] = HashMod - 61'd1;
        bases[2] = HashMod;
        bases[3] = 61'd1;
        bases[4] = 61'd0;
        bases[5] = HashW'({$urandom, $urandom}) & HashMod;
        drop_sequence();
        for (int i = 0; i < MaxLen + 2; i++) suf_hash[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items on the reset base
        add_item(ReqRev, 0, 0, 0);
        add_item(ReqSeal, 0, 0, 0);
        add_item(ReqRev, 0, 0, 0);
        add_item(ReqFwd, 0, 0, 0);
        add_item(ReqAppend, 32'h0, 12'hFFF, 12'hFFF);
        add_item(ReqAppend, 32'hFFFF_FFFF, 0, 0);
        add_item(ReqAppend, 32'd5, 0, 0);
        add_item(ReqFwd, 0, 0, 2);
        add_item(ReqFwd, 0, 1, 1);
        add_item(ReqFwd, 0, 2, 1);
        add_item(ReqFwd, 0, 0, 3);
        add_item(ReqRev, 0, 0, 2);
        add_item(ReqSeal, 0, 0, 0);
        add_item(ReqRev, 0, 0, 2);
        add_item(ReqRev, 0, 2, 2);
        add_item(ReqRev, 0, 1, 0);
        add_item(ReqAppend, 32'd7, 0, 0);
        add_item(ReqRev, 0, 0, 0);
        add_item(ReqSpare, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF);
        add_item(3'd6, 0, 0, 0);
        add_item(3'd7, 0, 0, 0);
        add_item(ReqClear, 0, 0, 0);
        add_item(ReqFwd, 0, 0, 0);
        random_items(150);
        drain();

        // Sweep of bases, including the extremes and the modulus itself
        for (int b = 0; b < 6; b++) begin
            write_base(bases[b]);
            quiet = (b == 2);
            random_items(130);
            drain();
        end
        quiet = 0;

        // Build a long sequence and query its widest range
        write_base(HashMod - 61'd1);
        repeat (LongLen) add_item(ReqAppend, $urandom, 12'd0, 12'd0);
        add_item(ReqFwd, 0, 12'd0, 12'(LongLen - 1));
        add_item(ReqRev, 0, 12'd0, 12'(LongLen - 1));
        add_item(ReqSeal, 0, 0, 0);
        add_item(ReqRev, 0, 12'd0, 12'(LongLen - 1));
        add_item(ReqRev, 0, 12'(LongLen - 1), 12'(LongLen - 1));
        add_item(ReqFwd, 0, 12'(LongLen), 12'(LongLen));
        drain();
        write_base(BaseReset);
        random_items(100);
        drain();

        $display("Covered %0d items and %0d results over %0d base writes,", n_items,
                 n_results, n_bases);
        $display("including a long sequence, empty seals and unused request codes.");
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/sphe_pkg.sv
rtl/core/sphe_ram.sv
rtl/core/sphe_mulmod.sv
rtl/core/substring_poly_hash_engine_unit.sv
test/tb.sv
